// File: rtl/hsvrgb_pkg.sv
// Shared types and constants for the HSV to RGB converter pipeline.
// No dependencies; every other rtl file refers to this package by scoped names.
package hsvrgb_pkg;

  localparam int FRAC_BITS = 16;
  localparam int Q1_W      = FRAC_BITS + 1;     // Q1.FRAC_BITS
  localparam int HH_W      = FRAC_BITS + 3;     // hue * 6, Q3.FRAC_BITS
  localparam int PROD_W    = 2 * Q1_W;

  localparam logic [Q1_W-1:0] FX_ONE = Q1_W'(1) << FRAC_BITS;

  // Hue sector, named by the span of the color wheel it covers
  typedef enum logic [2:0] {
    SECT_RED_YEL = 3'd0,
    SECT_YEL_GRN = 3'd1,
    SECT_GRN_CYN = 3'd2,
    SECT_CYN_BLU = 3'd3,
    SECT_BLU_MAG = 3'd4,
    SECT_MAG_RED = 3'd5
  } sector_t;

  typedef struct packed {
    logic [FRAC_BITS-1:0] hue;
    logic [Q1_W-1:0]      saturation;
    logic [Q1_W-1:0]      brightness;
  } hsv_t;

  typedef struct packed {
    logic [Q1_W-1:0] red;
    logic [Q1_W-1:0] green;
    logic [Q1_W-1:0] blue;
  } rgb_t;

  // After stage 1: clamped inputs, sector and fraction
  typedef struct packed {
    sector_t              sector;
    logic                 grey;
    logic [FRAC_BITS-1:0] frac;
    logic [Q1_W-1:0]      sat;
    logic [Q1_W-1:0]      val;
  } sect_st_t;

  // After stage 2: the three factors (1-s), (1-s*f), (1-s*(1-f))
  typedef struct packed {
    sector_t         sector;
    logic            grey;
    logic [Q1_W-1:0] kp;
    logic [Q1_W-1:0] kq;
    logic [Q1_W-1:0] kt;
    logic [Q1_W-1:0] val;
  } fact_st_t;

  // After stage 3: p, q, t scaled by value
  typedef struct packed {
    sector_t         sector;
    logic            grey;
    logic [Q1_W-1:0] p;
    logic [Q1_W-1:0] q;
    logic [Q1_W-1:0] t;
    logic [Q1_W-1:0] val;
  } scl_st_t;

  // Stage load enables from the top-level flow control
  typedef struct packed {
    logic sect;
    logic fact;
    logic scl;
  } stage_en_t;

endpackage

// File: rtl/hsvrgb_sector.sv
// Stage 1: clamps saturation and value to 1.0, splits hue * 6 into sector and fraction.
// Depends on hsvrgb_pkg.
module hsvrgb_sector (
  input  logic                clk,
  input  logic                en,
  input  hsvrgb_pkg::hsv_t     req,
  output hsvrgb_pkg::sect_st_t st_r
);

  logic [hsvrgb_pkg::Q1_W-1:0] sat_c;
  logic [hsvrgb_pkg::Q1_W-1:0] val_c;
  logic [hsvrgb_pkg::HH_W-1:0] hh;
  hsvrgb_pkg::sect_st_t        st_nxt;

  always_comb begin
    sat_c = (req.saturation > hsvrgb_pkg::FX_ONE) ? hsvrgb_pkg::FX_ONE : req.saturation;
    val_c = (req.brightness > hsvrgb_pkg::FX_ONE) ? hsvrgb_pkg::FX_ONE : req.brightness;
    // hue * 6 as shift-add
    hh = (hsvrgb_pkg::HH_W'(req.hue) << 2) + (hsvrgb_pkg::HH_W'(req.hue) << 1);

    st_nxt.sector = hsvrgb_pkg::sector_t'(hh[hsvrgb_pkg::HH_W-1 -: 3]);
    st_nxt.grey   = (sat_c == '0);
    st_nxt.frac   = hh[hsvrgb_pkg::FRAC_BITS-1:0];
    st_nxt.sat    = sat_c;
    st_nxt.val    = val_c;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      st_r <= st_nxt;
    end
  end

endmodule

// File: rtl/hsvrgb_factor.sv
// Stage 2: forms the factors 1-s, 1-s*f and 1-s*(1-f), products truncated.
// Depends on hsvrgb_pkg.
module hsvrgb_factor (
  input  logic                 clk,
  input  logic                 en,
  input  hsvrgb_pkg::sect_st_t  st_in,
  output hsvrgb_pkg::fact_st_t  st_r
);

  localparam int FB = hsvrgb_pkg::FRAC_BITS;
  localparam int QW = hsvrgb_pkg::Q1_W;
  localparam int PW = hsvrgb_pkg::PROD_W;

  logic [QW-1:0]        frac_c;    // 1 - f
  logic [PW-1:0]        prod_sf;
  logic [PW-1:0]        prod_sfc;
  hsvrgb_pkg::fact_st_t st_nxt;

  always_comb begin
    frac_c   = hsvrgb_pkg::FX_ONE - QW'(st_in.frac);
    prod_sf  = PW'(st_in.sat) * PW'(st_in.frac);
    prod_sfc = PW'(st_in.sat) * PW'(frac_c);

    st_nxt.sector = st_in.sector;
    st_nxt.grey   = st_in.grey;
    st_nxt.kp     = hsvrgb_pkg::FX_ONE - st_in.sat;
    // both truncated products stay within 0..1.0
    st_nxt.kq     = hsvrgb_pkg::FX_ONE - prod_sf[FB +: QW];
    st_nxt.kt     = hsvrgb_pkg::FX_ONE - prod_sfc[FB +: QW];
    st_nxt.val    = st_in.val;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      st_r <= st_nxt;
    end
  end

endmodule

// File: rtl/hsvrgb_scale.sv
// Stage 3: scales the three factors by value to give p, q and t.
// Depends on hsvrgb_pkg.
module hsvrgb_scale (
  input  logic                 clk,
  input  logic                 en,
  input  hsvrgb_pkg::fact_st_t  st_in,
  output hsvrgb_pkg::scl_st_t   st_r
);

  localparam int FB = hsvrgb_pkg::FRAC_BITS;
  localparam int QW = hsvrgb_pkg::Q1_W;
  localparam int PW = hsvrgb_pkg::PROD_W;

  logic [PW-1:0]       prod_p;
  logic [PW-1:0]       prod_q;
  logic [PW-1:0]       prod_t;
  hsvrgb_pkg::scl_st_t st_nxt;

  always_comb begin
    prod_p = PW'(st_in.val) * PW'(st_in.kp);
    prod_q = PW'(st_in.val) * PW'(st_in.kq);
    prod_t = PW'(st_in.val) * PW'(st_in.kt);

    st_nxt.sector = st_in.sector;
    st_nxt.grey   = st_in.grey;
    st_nxt.p      = prod_p[FB +: QW];
    st_nxt.q      = prod_q[FB +: QW];
    st_nxt.t      = prod_t[FB +: QW];
    st_nxt.val    = st_in.val;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      st_r <= st_nxt;
    end
  end

endmodule

// File: rtl/hsv_to_rgb_converter.sv
// HSV to RGB converter, top level: flow control, sector ordering, output register.
// Depends on hsvrgb_pkg, hsvrgb_sector, hsvrgb_factor and hsvrgb_scale.
//
// Converts one color per clock, while not stalled, from hue (Q0.16 fraction of a
// turn), saturation and value (Q1.16, clamped to 1.0) into red, green and blue
// (Q1.16). A request passes four register stages: sector split, factor multiply,
// value multiply, then channel ordering into the output register. Throughput is
// one request per cycle while in_stall is low; each stage holds its own valid bit
// and loads whenever it is empty or its contents move on, so bubbles close up and
// in_stall rises only when all four stages are full behind a stalled output. Zero
// saturation gives grey.
module hsv_to_rgb_converter (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_stall,
  input  hsvrgb_pkg::hsv_t in_data,
  output logic             out_valid,
  input  logic             out_stall,
  output hsvrgb_pkg::rgb_t out_data
);

  hsvrgb_pkg::stage_en_t en;
  logic                  out_en;
  logic                  v1_r, v2_r, v3_r, out_valid_r;

  hsvrgb_pkg::sect_st_t  sect_st;
  hsvrgb_pkg::fact_st_t  fact_st;
  hsvrgb_pkg::scl_st_t   scl_st;
  hsvrgb_pkg::rgb_t      rgb_nxt;
  hsvrgb_pkg::rgb_t      out_data_r;

  // A stage loads when it is empty or its contents move on this cycle
  always_comb begin
    out_en   = ~out_valid_r | ~out_stall;
    en.scl   = ~v3_r | out_en;
    en.fact  = ~v2_r | en.scl;
    en.sect  = ~v1_r | en.fact;
    in_stall = ~en.sect;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r        <= 1'b0;
      v2_r        <= 1'b0;
      v3_r        <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (en.sect) begin
        v1_r <= in_valid;
      end
      if (en.fact) begin
        v2_r <= v1_r;
      end
      if (en.scl) begin
        v3_r <= v2_r;
      end
      if (out_en) begin
        out_valid_r <= v3_r;
      end
    end
  end

  hsvrgb_sector u_sector (
    .clk  (clk),
    .en   (en.sect),
    .req  (in_data),
    .st_r (sect_st)
  );

  hsvrgb_factor u_factor (
    .clk   (clk),
    .en    (en.fact),
    .st_in (sect_st),
    .st_r  (fact_st)
  );

  hsvrgb_scale u_scale (
    .clk   (clk),
    .en    (en.scl),
    .st_in (fact_st),
    .st_r  (scl_st)
  );

  always_comb begin
    case (scl_st.sector)
      hsvrgb_pkg::SECT_RED_YEL: begin
        rgb_nxt.red = scl_st.val; rgb_nxt.green = scl_st.t; rgb_nxt.blue = scl_st.p;
      end
      hsvrgb_pkg::SECT_YEL_GRN: begin
        rgb_nxt.red = scl_st.q; rgb_nxt.green = scl_st.val; rgb_nxt.blue = scl_st.p;
      end
      hsvrgb_pkg::SECT_GRN_CYN: begin
        rgb_nxt.red = scl_st.p; rgb_nxt.green = scl_st.val; rgb_nxt.blue = scl_st.t;
      end
      hsvrgb_pkg::SECT_CYN_BLU: begin
        rgb_nxt.red = scl_st.p; rgb_nxt.green = scl_st.q; rgb_nxt.blue = scl_st.val;
      end
      hsvrgb_pkg::SECT_BLU_MAG: begin
        rgb_nxt.red = scl_st.t; rgb_nxt.green = scl_st.p; rgb_nxt.blue = scl_st.val;
      end
      default: begin
        rgb_nxt.red = scl_st.val; rgb_nxt.green = scl_st.p; rgb_nxt.blue = scl_st.q;
      end
    endcase
    if (scl_st.grey) begin
      rgb_nxt.red   = scl_st.val;
      rgb_nxt.green = scl_st.val;
      rgb_nxt.blue  = scl_st.val;
    end
  end

  always_ff @(posedge clk) begin
    if (out_en) begin
      out_data_r <= rgb_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

// File: tb/tb_hsv_to_rgb_converter.sv
// Self-checking testbench for hsv_to_rgb_converter: directed corners, then random colors
// under several flow-control mixes, checked against an in-bench fixed-point model.
// Depends on hsvrgb_pkg and rtl/hsv_to_rgb_converter.sv.
`timescale 1ns / 1ps

module tb_hsv_to_rgb_converter;

  localparam int CLK_HALF_NS  = 5;
  localparam int TIMEOUT_NS   = 2_000_000;
  localparam int DRAIN_CYCLES = 20;
  localparam int HOLD_CYCLES  = 80;
  localparam int HUE_SECTORS  = 6;
  localparam int QW           = hsvrgb_pkg::Q1_W;
  localparam int FB           = hsvrgb_pkg::FRAC_BITS;
  localparam int HW           = hsvrgb_pkg::HH_W;
  localparam int PW           = hsvrgb_pkg::PROD_W;

  logic clk      = 1'b0;
  logic rst_n    = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  hsvrgb_pkg::hsv_t in_data = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  hsvrgb_pkg::rgb_t out_data;

  hsvrgb_pkg::hsv_t hsv_pending_q[$];
  hsvrgb_pkg::rgb_t rgb_expected_q[$];

  int send_idle_pct   = 0;
  int stall_pct       = 0;
  int mismatch_cnt    = 0;
  int checked_cnt     = 0;
  int sent_cnt        = 0;
  int in_backpress    = 0;
  int phase_cnt       = 0;
  int hold_left       = 0;
  logic hold_req      = 1'b0;

  hsv_to_rgb_converter dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data (out_data)
  );

  always #CLK_HALF_NS clk = ~clk;

  // ---------------------------------------------------------------- predictor

  function automatic logic [QW-1:0] clamp_unit(input logic [QW-1:0] x);
    return (x > hsvrgb_pkg::FX_ONE) ? hsvrgb_pkg::FX_ONE : x;
  endfunction

  // a * b in Q1.FRAC_BITS, low fraction bits dropped
  function automatic logic [QW-1:0] fx_mul(input logic [QW-1:0] a,
                                           input logic [QW-1:0] b);
    logic [PW-1:0] prod;
    prod = PW'(a) * PW'(b);
    return prod[FB +: QW];
  endfunction

  function automatic hsvrgb_pkg::rgb_t convert_hsv(input hsvrgb_pkg::hsv_t px);
    logic [QW-1:0]       sat, val, frac, p, q, t;
    logic [HW-1:0]       hh;
    hsvrgb_pkg::sector_t sect;
    hsvrgb_pkg::rgb_t    res;
    sat = clamp_unit(px.saturation);
    val = clamp_unit(px.brightness);
    if (sat == '0) begin
      res.red   = val;
      res.green = val;
      res.blue  = val;
    end else begin
      hh   = HW'(px.hue) * HW'(HUE_SECTORS);
      sect = hsvrgb_pkg::sector_t'(hh[HW-1:FB]);
      frac = QW'(hh[FB-1:0]);
      p    = fx_mul(val, hsvrgb_pkg::FX_ONE - sat);
      q    = fx_mul(val, hsvrgb_pkg::FX_ONE - fx_mul(sat, frac));
      t    = fx_mul(val, hsvrgb_pkg::FX_ONE - fx_mul(sat, hsvrgb_pkg::FX_ONE - frac));
      case (sect)
        hsvrgb_pkg::SECT_RED_YEL: res = '{red: val, green: t,   blue: p};
        hsvrgb_pkg::SECT_YEL_GRN: res = '{red: q,   green: val, blue: p};
        hsvrgb_pkg::SECT_GRN_CYN: res = '{red: p,   green: val, blue: t};
        hsvrgb_pkg::SECT_CYN_BLU: res = '{red: p,   green: q,   blue: val};
        hsvrgb_pkg::SECT_BLU_MAG: res = '{red: t,   green: p,   blue: val};
        default:                  res = '{red: val, green: p,   blue: q};  // magenta to red
      endcase
    end
    return res;
  endfunction

  // ---------------------------------------------------------------- checking

  task automatic report_mismatch(input string what, input logic [QW-1:0] got,
                                 input logic [QW-1:0] want);
    $display("[%0t] MISMATCH %s: got %0d, want %0d", $realtime, what, got, want);
    mismatch_cnt++;
  endtask

  // ---------------------------------------------------------------- driver

  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        rgb_expected_q.push_back(convert_hsv(in_data));
        sent_cnt++;
      end
      if (in_valid && in_stall) begin
        in_backpress++;
      end else if (hsv_pending_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        in_valid <= 1'b1;
        in_data  <= hsv_pending_q.pop_front();
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // ---------------------------------------------------------------- monitor

  always @(posedge clk) begin
    if (hold_req) begin
      hold_left <= HOLD_CYCLES;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end
  end

  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      out_stall <= hold_req || (hold_left != 0) || ($urandom_range(99) < stall_pct);
    end
  end

  always @(posedge clk) begin : check_result
    hsvrgb_pkg::rgb_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (rgb_expected_q.size() == 0) begin
        report_mismatch("result with no request pending", out_data.red, '0);
      end else begin
        want = rgb_expected_q.pop_front();
        if (out_data.red !== want.red)     report_mismatch("red", out_data.red, want.red);
        if (out_data.green !== want.green) report_mismatch("green", out_data.green, want.green);
        if (out_data.blue !== want.blue)   report_mismatch("blue", out_data.blue, want.blue);
        checked_cnt++;
      end
    end
  end

  // ---------------------------------------------------------------- stimulus

  task automatic queue_color(input int h, input int s, input int v);
    hsvrgb_pkg::hsv_t px;
    px.hue        = FB'(h);
    px.saturation = QW'(s);
    px.brightness = QW'(v);
    hsv_pending_q.push_back(px);
  endtask

  function automatic logic [QW-1:0] random_q1();
    int mode;
    mode = $urandom_range(99);
    if (mode < 8)       return '0;
    else if (mode < 14) return hsvrgb_pkg::FX_ONE;
    else if (mode < 85) return QW'($urandom_range(int'(hsvrgb_pkg::FX_ONE)));
    else                return QW'($urandom);  // may exceed 1.0
  endfunction

  task automatic queue_random(input int count);
    hsvrgb_pkg::hsv_t px;
    repeat (count) begin
      px.hue        = FB'($urandom);
      px.saturation = random_q1();
      px.brightness = random_q1();
      hsv_pending_q.push_back(px);
    end
  endtask

  task automatic set_flow(input int idle_pct, input int stall_in_pct);
    send_idle_pct = idle_pct;
    stall_pct     = stall_in_pct;
    phase_cnt++;
  endtask

  task automatic wait_sent();
    while (hsv_pending_q.size() != 0) @(negedge clk);
  endtask

  initial begin
    #TIMEOUT_NS;
    $display("Mismatches found");
    $finish;
  end

  initial begin
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // directed corners: grey, sector edges, clamping of saturation and value
    set_flow(0, 0);
    queue_color(0, 0, 0);
    queue_color(65535, 65536, 65536);
    queue_color(0, 0, 65536);
    queue_color(12345, 0, 40000);
    queue_color(100, 0, 131071);
    queue_color(0, 65536, 65536);
    queue_color(10922, 65536, 65536);
    queue_color(10923, 65536, 65536);
    queue_color(21845, 65536, 65536);
    queue_color(21846, 65536, 65536);
    queue_color(32768, 65536, 65536);
    queue_color(43690, 65536, 65536);
    queue_color(43691, 65536, 65536);
    queue_color(54613, 65536, 65536);
    queue_color(54614, 65536, 65536);
    queue_color(5000, 131071, 30000);
    queue_color(40000, 70000, 131071);
    queue_color(30000, 65537, 65537);
    queue_color(20000, 1, 65536);
    queue_color(50000, 32768, 0);
    queue_color(60000, 98304, 65535);
    wait_sent();

    set_flow(0, 0);
    queue_random(250);
    wait_sent();

    set_flow(71, 0);
    queue_random(200);
    wait_sent();

    set_flow(0, 71);
    queue_random(200);
    wait_sent();

    set_flow(12, 12);
    queue_random(200);
    wait_sent();

    // long output hold with the input kept busy, so the pipe fills and backs up
    set_flow(0, 0);
    queue_random(50);
    hold_req = 1'b1;
    @(negedge clk);
    hold_req = 1'b0;
    wait_sent();

    while (in_valid || rgb_expected_q.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);

    if (rgb_expected_q.size() != 0)
      report_mismatch("results never returned", '0, QW'(rgb_expected_q.size()));

    $display("Converted %0d colors (%0d checked) across %0d flow-control phases;",
             sent_cnt, checked_cnt, phase_cnt);
    $display("input was held back by a full pipeline for %0d cycles.", in_backpress);
    if (mismatch_cnt == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

// File: sim.f
rtl/hsvrgb_pkg.sv
rtl/hsvrgb_sector.sv
rtl/hsvrgb_factor.sv
rtl/hsvrgb_scale.sv
rtl/hsv_to_rgb_converter.sv
tb/tb_hsv_to_rgb_converter.sv
